/* rtl/core/mwo_pkg.sv */
// ----------------------------------------------------------------------------
// mwo_pkg
// Constants, table types and build-time table generators for the modulated
// wavetable oscillator: the Q1.15 sine table and the per-semitone increments.
// ----------------------------------------------------------------------------
`default_nettype none

package mwo_pkg;

   localparam int TableEntries = 1024;
   localparam int SampleHz     = 48000;
   localparam int IndexBits    = $clog2(TableEntries);
   localparam int PhFrac       = 16;
   localparam int PhaseBits    = IndexBits + PhFrac;
   localparam int SemiBits     = 6;
   localparam int SemiMax      = 48;
   localparam int SemiPerOct   = 12;
   localparam int SampleBits   = 16;
   // Carrier sum: phase + increment + deviation, with a sign bit and a carry.
   localparam int SumBits      = PhaseBits + 2;

   localparam longint unsigned C1CentiHz = 64'd3270;
   localparam longint unsigned Q30One    = 64'd1 << 30;
   localparam longint unsigned HalfPiQ30 = 64'd1686629713;
   localparam longint unsigned Q24One    = 64'd1 << 24;

   typedef logic [SemiBits-1:0]          semi_type;
   typedef logic [IndexBits-1:0]         index_type;
   typedef logic [PhaseBits-1:0]         phase_type;
   typedef logic signed [SampleBits-1:0] sample_type;

   typedef sample_type sine_table_type [TableEntries];
   typedef phase_type  inc_table_type [SemiMax+1];

   // Truncating unsigned quotient by shift and subtract, for table generation.
   function automatic longint unsigned udiv(longint unsigned num,
                                            longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // One sine entry: Q32 turn folded to the first quadrant, Q30 Taylor series.
   function automatic sample_type sine_entry(longint unsigned idx);
      longint unsigned turn;
      longint unsigned r;
      longint unsigned x;
      longint unsigned sum;
      longint unsigned term;
      longint unsigned mag;
      longint unsigned div;
      longint unsigned quad;
      sample_type      mag16;
      turn = (idx << 32) >> IndexBits;
      quad = (turn >> 30) & 64'd3;
      r = turn & (Q30One - 64'd1);
      if (quad[0]) begin
         r = Q30One - r;
      end
      x = (r * HalfPiQ30) >> 30;
      sum = x;
      term = x;
      for (int k = 1; k <= 7; k++) begin
         div = longint'(2 * k) * longint'(2 * k + 1);
         term = udiv((((term * x) >> 30) * x) >> 30, div);
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      mag = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      mag16 = sample_type'(mag[SampleBits-1:0]);
      return (quad >= 64'd2) ? -mag16 : mag16;
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      for (int i = 0; i < TableEntries; i++) begin
         tbl[i] = sine_entry(longint'(i));
      end
      return tbl;
   endfunction

   // Truncated twelfth power in Q24, saturating just above the target.
   function automatic longint unsigned pow12_q24(longint unsigned r,
                                                 longint unsigned target);
      longint unsigned p;
      logic            over;
      p = Q24One;
      over = 1'b0;
      for (int i = 0; i < 12; i++) begin
         if (!over) begin
            p = (p * r) >> 24;
            if (p > target) begin
               over = 1'b1;
            end
         end
      end
      return over ? target + 64'd1 : p;
   endfunction

   // Largest Q24 ratio whose twelfth power stays at or below 2^k.
   function automatic longint unsigned semitone_ratio(int k);
      longint unsigned target;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      target = 64'd1 << (k + 24);
      lo = Q24One;
      hi = Q24One << 1;
      for (int i = 0; i < 24; i++) begin
         if (hi - lo > 64'd1) begin
            mid = (lo + hi) >> 1;
            if (pow12_q24(mid, target) <= target) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end
      end
      return lo;
   endfunction

   function automatic inc_table_type build_inc_table();
      inc_table_type   tbl;
      longint unsigned r;
      longint unsigned num;
      longint unsigned den;
      longint unsigned inc;
      int              semi;
      int              oct;
      den = (64'd100 * longint'(SampleHz)) << 8;
      semi = 0;
      oct = 0;
      for (int n = 0; n <= SemiMax; n++) begin
         r = semitone_ratio(semi) << oct;
         num = r * longint'(TableEntries) * C1CentiHz;
         inc = udiv(num + den / 64'd2, den);
         tbl[n] = phase_type'(inc[PhaseBits-1:0]);
         // Step through the octave, wrapping the semitone within it.
         if (semi == SemiPerOct - 1) begin
            semi = 0;
            oct = oct + 1;
         end else begin
            semi = semi + 1;
         end
      end
      return tbl;
   endfunction

   localparam sine_table_type SineTable = build_sine_table();
   localparam inc_table_type  IncTable  = build_inc_table();

endpackage

`default_nettype wire

/* rtl/core/mwo_sine_rom.sv */
// ----------------------------------------------------------------------------
// mwo_sine_rom
// Single-port Q1.15 sine table with a registered read and a read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module mwo_sine_rom (
   input  wire                  clock,
   input  wire                  en,
   input  wire mwo_pkg::index_type  addr,
   output mwo_pkg::sample_type  data
);
   import mwo_pkg::*;

   sample_type rom_mem [TableEntries];
   sample_type data_ff;

   always_comb begin
      rom_mem = SineTable;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= rom_mem[addr];
      end
   end

   assign data = data_ff;

endmodule

`default_nettype wire

/* rtl/core/modulated_wavetable_oscillator.sv */
// ----------------------------------------------------------------------------
// modulated_wavetable_oscillator
// DDS sine oscillator with phase modulation: a modulator phase reads the sine
// table, and its value bends the increment of the left and right carriers.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata bits (low to high)                  tuser/tlast
//  req_      in         pitch_semitone[5:0], mod_semitone[11:6]   none
//  rsp_      out        left_sample[15:0], right_sample[31:16]    none
//
// One request is taken every clock cycle while the output is not stalled;
// its sample pair is offered after the modulator table read, then the carrier
// update with its table read, whose registered data drives rsp_tdata. The
// carrier phase loop sets the rate. A stalled output freezes the whole
// pipeline, and req_tready follows it. Reset clears the three phases and the
// pipeline valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module modulated_wavetable_oscillator (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // pitch_semitone[5:0], mod_semitone[11:6]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata    // left_sample[15:0], right_sample[31:16]
);
   import mwo_pkg::*;

   logic       pipe_en;
   logic       req_fire;
   semi_type   pitch_sel;
   semi_type   mod_sel;

   phase_type  mod_phase_ff;
   phase_type  mod_phase_in;
   phase_type  pinc_ff;
   logic       valid1_ff;
   logic       valid2_ff;

   phase_type  left_phase_ff;
   phase_type  left_phase_in;
   phase_type  right_phase_ff;
   phase_type  right_phase_in;

   sample_type mod_sample;
   sample_type left_sample;
   sample_type right_sample;

   function automatic semi_type clamp_semi(semi_type v);
      return (v > semi_type'(SemiMax)) ? semi_type'(SemiMax) : v;
   endfunction

   // Adds the increment and twice the modulator sample; a negative sum
   // clamps to zero, and the low bits give the wrap.
   function automatic phase_type advance(phase_type ph, phase_type inc,
                                         sample_type dev);
      logic signed [SumBits-1:0] sum;
      sum = $signed({2'b00, ph}) + $signed({2'b00, inc})
          + $signed({{(SumBits-SampleBits-1){dev[SampleBits-1]}}, dev, 1'b0});
      return sum[SumBits-1] ? '0 : sum[PhaseBits-1:0];
   endfunction

   assign pipe_en    = !valid2_ff || rsp_tready;
   assign req_tready = pipe_en;
   assign req_fire   = req_tvalid && pipe_en;

   assign pitch_sel = clamp_semi(req_tdata[SemiBits-1:0]);
   assign mod_sel   = clamp_semi(req_tdata[2*SemiBits-1:SemiBits]);

   assign mod_phase_in   = req_fire ? mod_phase_ff + IncTable[mod_sel] : mod_phase_ff;
   assign left_phase_in  = (pipe_en && valid1_ff) ?
                           advance(left_phase_ff, pinc_ff, mod_sample) : left_phase_ff;
   assign right_phase_in = (pipe_en && valid1_ff) ?
                           advance(right_phase_ff, pinc_ff, mod_sample) : right_phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_phase_ff   <= '0;
         left_phase_ff  <= '0;
         right_phase_ff <= '0;
         valid1_ff      <= 1'b0;
         valid2_ff      <= 1'b0;
      end else begin
         mod_phase_ff   <= mod_phase_in;
         left_phase_ff  <= left_phase_in;
         right_phase_ff <= right_phase_in;
         if (pipe_en) begin
            valid1_ff <= req_tvalid;
            valid2_ff <= valid1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pinc_ff <= IncTable[pitch_sel];
      end
   end

   mwo_sine_rom u_mod_rom (
      .clock (clock),
      .en    (req_fire),
      .addr  (mod_phase_in[PhaseBits-1:PhFrac]),
      .data  (mod_sample)
   );

   mwo_sine_rom u_left_rom (
      .clock (clock),
      .en    (pipe_en),
      .addr  (left_phase_in[PhaseBits-1:PhFrac]),
      .data  (left_sample)
   );

   mwo_sine_rom u_right_rom (
      .clock (clock),
      .en    (pipe_en),
      .addr  (right_phase_in[PhaseBits-1:PhFrac]),
      .data  (right_sample)
   );

   assign rsp_tvalid = valid2_ff;
   assign rsp_tdata  = {right_sample, left_sample};

endmodule

`default_nettype wire

/* rtl/core/mwo_checker.sv */
// ----------------------------------------------------------------------------
// mwo_checker
// Port-level checks for the oscillator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mwo_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire [15:0] req_tdata,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata
);

   // A request held back by the block keeps its fields.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("request changed while stalled");

   // A response held back by the sink keeps its samples.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Both channels run the same phase, so the samples always agree.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] == rsp_tdata[31:16])
      else $error("left and right samples differ");

   // The sine table is symmetric and never reaches full negative scale.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] != 16'h8000)
      else $error("sample outside the Q1.15 table range");

   // Nothing comes out right after reset, before any request could pass.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind modulated_wavetable_oscillator mwo_checker u_mwo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
